>>> rtl/msam_pkg.sv
// Shared types and constants for the multi-stream audio mixer.
// Used by msam_cell, msam_master and the top level; no dependencies.
package msam_pkg;

  localparam int unsigned STREAMS_DEFAULT = 4;
  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned GAIN_W          = 20;
  // trunc(v * g / 65536) for a 16-bit signed v and 20-bit gain fits 20 bits signed
  localparam int unsigned TERM_W          = 20;
  localparam int unsigned FRAC_W          = 16;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MUTE_ALL      = 1'd1;

  // sample format codes; the unused code behaves like native 16-bit
  localparam logic [1:0] FMT_U8       = 2'd0;
  localparam logic [1:0] FMT_S16      = 2'd1;
  localparam logic [1:0] FMT_S16_SWAP = 2'd2;

  // saturation limits
  localparam logic signed [SAMPLE_W-1:0] S8_MIN  = -16'sh0080;
  localparam logic signed [SAMPLE_W-1:0] S8_MAX  = 16'sh007F;
  localparam logic signed [SAMPLE_W-1:0] S16_MIN = -16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7FFF;

  // silence codes
  localparam logic [SAMPLE_W-1:0] SILENCE_U8  = 16'h0080;
  localparam logic [SAMPLE_W-1:0] SILENCE_S16 = 16'h0000;

  typedef struct packed {
    logic eight;    // 8-bit offset binary
    logic swapped;  // 16-bit byte-swapped
  } fmt_t;

endpackage

>>> rtl/msam_cell.sv
// One stream cell of the mixer chain: decodes its stream sample, applies the gain
// and adds the term to the running sum handed on by the previous cell. Uses msam_pkg.
module msam_cell
  import msam_pkg::*;
#(
  parameter int unsigned STREAMS = STREAMS_DEFAULT,
  parameter int unsigned IDX     = 0,
  localparam int unsigned CNT_W  = $clog2(STREAMS + 1),
  localparam int unsigned ITEM_W = STREAMS * (SAMPLE_W + GAIN_W) + GAIN_W + CNT_W,
  localparam int unsigned SUM_W  = TERM_W + $clog2(STREAMS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  fmt_t                    fmt_i,
  input  logic                    valid_i,
  input  logic [ITEM_W-1:0]       item_i,
  input  logic signed [SUM_W-1:0] sum_i,
  output logic                    valid_o,
  output logic [ITEM_W-1:0]       item_o,
  output logic signed [SUM_W-1:0] sum_o
);

  localparam int unsigned PROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int unsigned GAIN_LSB = STREAMS * SAMPLE_W + IDX * GAIN_W;
  localparam int unsigned CNT_LSB  = STREAMS * (SAMPLE_W + GAIN_W) + GAIN_W;

  logic [SAMPLE_W-1:0]        raw;
  logic [GAIN_W-1:0]          gain;
  logic [CNT_W-1:0]           count;
  logic signed [SAMPLE_W-1:0] val;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   biased;
  logic signed [TERM_W-1:0]   term;
  logic                       active;

  logic                    valid_q;
  logic [ITEM_W-1:0]       item_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;

  assign raw   = item_i[IDX*SAMPLE_W +: SAMPLE_W];
  assign gain  = item_i[GAIN_LSB +: GAIN_W];
  assign count = item_i[CNT_LSB +: CNT_W];

  // a count above STREAMS still enables every cell
  assign active = (count > CNT_W'(IDX));

  always_comb begin
    if (fmt_i.eight) begin
      // offset binary: flip the top bit of the low byte and sign-extend
      val = {{8{~raw[7]}}, ~raw[7], raw[6:0]};
    end else if (fmt_i.swapped) begin
      val = {raw[7:0], raw[15:8]};
    end else begin
      val = raw;
    end
    prod   = PROD_W'(val) * PROD_W'($signed({1'b0, gain}));
    // bias negative products so the shift truncates toward zero
    biased = prod + (prod[PROD_W-1] ? PROD_W'({FRAC_W{1'b1}}) : '0);
    term   = biased[FRAC_W +: TERM_W];
    sum_d  = sum_i + (active ? SUM_W'(term) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_i;
      sum_q  <= sum_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign sum_o   = sum_q;

endmodule

>>> rtl/msam_master.sv
// Output end of the mixer: master gain, saturation to the format range, encoding,
// muting and the output word register. Uses msam_pkg.
module msam_master
  import msam_pkg::*;
#(
  parameter int unsigned STREAMS = STREAMS_DEFAULT,
  localparam int unsigned SUM_W  = TERM_W + $clog2(STREAMS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  fmt_t                    fmt_i,
  input  logic                    mute_i,
  input  logic                    valid_i,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic [GAIN_W-1:0]       gain_i,
  output logic                    valid_o,
  output logic [SAMPLE_W-1:0]     sample_o,
  output logic                    clipped_o
);

  localparam int unsigned MP_W  = SUM_W + GAIN_W + 1;
  localparam int unsigned MIX_W = MP_W - FRAC_W;

  logic signed [MP_W-1:0]  prod;
  logic signed [MP_W-1:0]  biased;
  logic signed [MIX_W-1:0] mix_d, mix_q;
  logic                    mix_valid_q;

  logic signed [MIX_W-1:0]    lo, hi;
  logic signed [SAMPLE_W-1:0] sat;
  logic [SAMPLE_W-1:0]        word_d, word_q;
  logic                       clip_d, clip_q;
  logic                       valid_q;

  // stage one: master gain
  always_comb begin
    prod   = MP_W'(sum_i) * MP_W'($signed({1'b0, gain_i}));
    biased = prod + (prod[MP_W-1] ? MP_W'({FRAC_W{1'b1}}) : '0);
    mix_d  = biased[MP_W-1:FRAC_W];
  end

  // stage two: saturate and encode
  always_comb begin
    lo     = fmt_i.eight ? MIX_W'(S8_MIN) : MIX_W'(S16_MIN);
    hi     = fmt_i.eight ? MIX_W'(S8_MAX) : MIX_W'(S16_MAX);
    clip_d = 1'b0;
    sat    = mix_q[SAMPLE_W-1:0];
    if (mix_q < lo) begin
      sat    = lo[SAMPLE_W-1:0];
      clip_d = 1'b1;
    end else if (mix_q > hi) begin
      sat    = hi[SAMPLE_W-1:0];
      clip_d = 1'b1;
    end
    if (fmt_i.eight) begin
      word_d = {8'h00, sat[7] ^ 1'b1, sat[6:0]};
    end else if (fmt_i.swapped) begin
      word_d = {sat[7:0], sat[15:8]};
    end else begin
      word_d = sat;
    end
    if (mute_i) begin
      word_d = fmt_i.eight ? SILENCE_U8 : SILENCE_S16;
      clip_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mix_valid_q <= 1'b0;
      valid_q     <= 1'b0;
    end else if (en_i) begin
      mix_valid_q <= valid_i;
      valid_q     <= mix_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mix_q  <= mix_d;
      word_q <= word_d;
      clip_q <= clip_d;
    end
  end

  assign valid_o   = valid_q;
  assign sample_o  = word_q;
  assign clipped_o = clip_q;

endmodule

>>> rtl/multi_stream_audio_mixer.sv
// Multi-stream audio mixer top level: configuration registers, the chain of stream
// cells and the output end. Uses msam_pkg, msam_cell and msam_master.
//
// Takes one word per clock and gives one mixed word per clock. Each word passes
// a row of STREAMS cells, one per stream, each adding its gained term to the
// running sum, then a master gain stage and a saturate/encode stage that is the
// output register. When the output word is not taken the whole row holds, bubbles
// inside it included, and the input is stalled.
// Configuration writes take effect at once and belong to quiet periods only.
module multi_stream_audio_mixer
  import msam_pkg::*;
#(
  parameter int unsigned STREAMS = STREAMS_DEFAULT,
  localparam int unsigned CNT_W   = $clog2(STREAMS + 1),
  localparam int unsigned ITEM_W  = STREAMS * (SAMPLE_W + GAIN_W) + GAIN_W + CNT_W,
  localparam int unsigned TDATA_W = ((ITEM_W + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_wdata_i,

  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // sample_a.. (16 b each), gain_a.. (20 b each), master_gain (20 b),
  // stream_count, zero padding
  input  logic [TDATA_W-1:0]   s_axis_tdata,

  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // mixed_sample (16 b)
  output logic [SAMPLE_W-1:0]  m_axis_tdata,
  // clipped (1 b)
  output logic                 m_axis_tuser
);

  localparam int unsigned SUM_W      = TERM_W + $clog2(STREAMS);
  localparam int unsigned MASTER_LSB = STREAMS * (SAMPLE_W + GAIN_W);

  logic [1:0] format_q;
  logic       mute_q;
  fmt_t       fmt;
  logic       en;

  logic                    valid_c [STREAMS+1];
  logic [ITEM_W-1:0]       item_c  [STREAMS+1];
  logic signed [SUM_W-1:0] sum_c   [STREAMS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= FMT_S16;
      mute_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SAMPLE_FORMAT: format_q <= cfg_wdata_i;
        REG_MUTE_ALL:      mute_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign fmt.eight   = (format_q == FMT_U8);
  assign fmt.swapped = (format_q == FMT_S16_SWAP);

  // advance the whole row unless the output word is held
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign valid_c[0] = s_axis_tvalid;
  assign item_c[0]  = s_axis_tdata[ITEM_W-1:0];
  assign sum_c[0]   = '0;

  for (genvar i = 0; i < STREAMS; i++) begin : g_cell
    msam_cell #(
      .STREAMS (STREAMS),
      .IDX     (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .fmt_i   (fmt),
      .valid_i (valid_c[i]),
      .item_i  (item_c[i]),
      .sum_i   (sum_c[i]),
      .valid_o (valid_c[i+1]),
      .item_o  (item_c[i+1]),
      .sum_o   (sum_c[i+1])
    );
  end

  msam_master #(
    .STREAMS (STREAMS)
  ) u_master (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .fmt_i     (fmt),
    .mute_i    (mute_q),
    .valid_i   (valid_c[STREAMS]),
    .sum_i     (sum_c[STREAMS]),
    .gain_i    (item_c[STREAMS][MASTER_LSB +: GAIN_W]),
    .valid_o   (m_axis_tvalid),
    .sample_o  (m_axis_tdata),
    .clipped_o (m_axis_tuser)
  );

endmodule

>>> tb/tb_multi_stream_audio_mixer.sv
// Self-checking testbench for multi_stream_audio_mixer: streams mix words in, predicts each
// mixed sample and clipped flag from its own model, and checks them against the output stream.
// Depends on msam_pkg and the mixer RTL only.
module tb_multi_stream_audio_mixer;
  import msam_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTR      = STREAMS_DEFAULT;
  localparam int TDATA_W   = 168;
  localparam int HOLD_LEN  = 400;
  localparam int MAX_PRINT = 100;

  // the fourth format code has no name in the package; it must act as native 16-bit
  localparam logic [1:0] FMT_UNUSED = 2'd3;

  // one mix word, laid out exactly as s_axis_tdata without its padding bit
  typedef struct packed {
    logic [2:0]             count;
    logic [GAIN_W-1:0]      master;
    logic [3:0][GAIN_W-1:0] gain;
    logic [3:0][15:0]       smp;
  } mix_word_t;

  typedef struct packed {
    logic [15:0] mixed;
    logic        clip;
  } mix_out_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i   = REG_SAMPLE_FORMAT;
  logic [CFG_DAT_W-1:0] cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;
  logic                 m_axis_tuser;

  // shadow of the block's registers, reset values
  logic [1:0] fmt_q  = FMT_S16;
  logic       mute_q = 1'b0;

  mix_out_t expected_mix_q[$];
  int       err_count    = 0;
  logic     src_gaps     = 1'b1;
  logic     snk_stalls   = 1'b1;
  logic     hold_pending = 1'b0;
  int       hold_left    = 0;

  multi_stream_audio_mixer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  // v * g / 65536, truncated toward zero
  function automatic longint scale_q16(input longint v, input longint g);
    longint p;
    p = v * g;
    if (p < 0) return -((-p) >> 16);
    return p >> 16;
  endfunction

  function automatic longint decode_sample(input logic [15:0] raw, input logic eight,
                                           input logic swapped);
    logic [15:0] w;
    longint      v;
    if (eight) begin
      v = longint'(raw[7:0]);
      return v - 128;
    end
    w = swapped ? {raw[7:0], raw[15:8]} : raw;
    v = longint'($signed(w));
    return v;
  endfunction

  function automatic mix_out_t predict_mix(input mix_word_t w);
    mix_out_t    r;
    logic        eight;
    logic        swapped;
    longint      lo;
    longint      hi;
    longint      acc;
    int          n;
    logic [63:0] enc;
    eight   = (fmt_q == FMT_U8);
    swapped = (fmt_q == FMT_S16_SWAP);
    lo      = eight ? longint'(S8_MIN) : longint'(S16_MIN);
    hi      = eight ? longint'(S8_MAX) : longint'(S16_MAX);
    n       = (w.count > NSTR) ? NSTR : int'(w.count);
    acc     = 0;
    r.clip  = 1'b0;
    if (!mute_q) begin
      for (int k = 0; k < n; k++)
        acc += scale_q16(decode_sample(w.smp[k], eight, swapped), longint'(w.gain[k]));
      acc = scale_q16(acc, longint'(w.master));
      if (acc < lo) begin
        acc    = lo;
        r.clip = 1'b1;
      end
      if (acc > hi) begin
        acc    = hi;
        r.clip = 1'b1;
      end
    end
    if (eight) begin
      enc     = acc + 128;
      r.mixed = {8'h00, enc[7:0]};
    end else begin
      enc     = acc;
      r.mixed = swapped ? {enc[7:0], enc[15:8]} : enc[15:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic mix_word_t mk_word(input logic [15:0] s, input logic [GAIN_W-1:0] g,
                                        input logic [GAIN_W-1:0] m, input logic [2:0] n);
    mix_word_t w;
    for (int k = 0; k < 4; k++) begin
      w.smp[k]  = s;
      w.gain[k] = g;
    end
    w.master = m;
    w.count  = n;
    return w;
  endfunction

  function automatic logic [15:0] rand_sample();
    logic [15:0] s;
    s = 16'($urandom);
    case ($urandom_range(7))
      0: s = 16'h7FFF;
      1: s = 16'h8000;
      2: s[7:0] = 8'hFF;
      3: s[7:0] = 8'h00;
      default: ;
    endcase
    return s;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(9))
      0: return '0;
      1: return 20'hFFFFF;
      2, 3: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(20'h1FFFF));
    endcase
  endfunction

  function automatic mix_word_t rand_word();
    mix_word_t w;
    for (int k = 0; k < 4; k++) begin
      w.smp[k]  = rand_sample();
      w.gain[k] = rand_gain();
    end
    w.master = rand_gain();
    if ($urandom_range(3) == 0) w.count = 3'($urandom_range(7));
    else w.count = 3'($urandom_range(4, 1));
    return w;
  endfunction

  task automatic send_word(input mix_word_t w);
    if (src_gaps) begin
      while ($urandom_range(99) < 22) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, w};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_mix_q.push_back(predict_mix(w));
  endtask

  // drop valid and wait until every mixed word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_mix_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [1:0] fmt, input logic mute);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_SAMPLE_FORMAT;
    cfg_wdata_i <= fmt;
    @(posedge clk_i);
    cfg_index_i <= REG_MUTE_ALL;
    cfg_wdata_i <= {($urandom_range(1) != 0), mute};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    fmt_q  = fmt;
    mute_q = mute;
    @(posedge clk_i);
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_word(rand_word());
    drain();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_edges();
    mix_word_t w;
    // reset settings: native 16-bit, not muted
    send_word(mk_word(16'h7FFF, 20'h10000, 20'h10000, 3'd1));
    send_word(mk_word(16'h8000, 20'h10000, 20'h10000, 3'd1));
    send_word(mk_word(16'h7FFF, 20'h10000, 20'h10000, 3'd4));
    send_word(mk_word(16'h8000, 20'h10000, 20'h10000, 3'd4));
    send_word(mk_word(16'hFFFF, 20'hFFFFF, 20'hFFFFF, 3'd7));
    send_word(mk_word(16'h1234, 20'h00000, 20'h10000, 3'd4));
    send_word(mk_word(16'h7FFF, 20'hFFFFF, 20'h00000, 3'd4));
    send_word(mk_word(16'h5555, 20'h10000, 20'h10000, 3'd0));
    send_word(mk_word(16'h0001, 20'h08000, 20'h10000, 3'd5));
    send_word(mk_word(16'hFFFF, 20'h18000, 20'h10000, 3'd1));
    w = mk_word(16'h0100, 20'h10000, 20'h10000, 3'd4);
    w.smp[3]  = 16'h8000;
    w.gain[1] = 20'h00000;
    send_word(w);
    drain();

    set_config(FMT_U8, 1'b0);
    send_word(mk_word(16'h00FF, 20'h10000, 20'h10000, 3'd1));
    send_word(mk_word(16'hAB00, 20'h10000, 20'h10000, 3'd4));
    send_word(mk_word(16'hFF7F, 20'h10000, 20'h10000, 3'd3));
    send_word(mk_word(16'h0080, 20'hFFFFF, 20'hFFFFF, 3'd4));
    drain();

    set_config(FMT_S16_SWAP, 1'b0);
    send_word(mk_word(16'hFF7F, 20'h10000, 20'h10000, 3'd1));
    send_word(mk_word(16'h0080, 20'h10000, 20'h10000, 3'd4));
    send_word(mk_word(16'h0100, 20'h10000, 20'h10000, 3'd2));
    drain();

    set_config(FMT_UNUSED, 1'b0);
    send_word(mk_word(16'h7FFF, 20'h10000, 20'h10000, 3'd2));
    send_word(mk_word(16'h1234, 20'h0C000, 20'h14000, 3'd3));
    drain();

    set_config(FMT_U8, 1'b1);
    send_word(mk_word(16'h7FFF, 20'hFFFFF, 20'hFFFFF, 3'd4));
    drain();
    set_config(FMT_S16, 1'b1);
    send_word(mk_word(16'h7FFF, 20'hFFFFF, 20'hFFFFF, 3'd4));
    drain();
    set_config(FMT_S16_SWAP, 1'b1);
    send_word(mk_word(16'h8000, 20'hFFFFF, 20'hFFFFF, 3'd4));
    drain();
  endtask

  task automatic test_random_formats();
    set_config(FMT_U8, 1'b0);
    send_random(320);
    set_config(FMT_S16, 1'b0);
    send_random(420);
    set_config(FMT_S16_SWAP, 1'b0);
    send_random(320);
    set_config(FMT_UNUSED, 1'b0);
    send_random(150);
  endtask

  task automatic test_muted();
    set_config(FMT_S16, 1'b1);
    send_random(70);
    set_config(FMT_U8, 1'b1);
    send_random(60);
    set_config(FMT_S16_SWAP, 1'b1);
    send_random(60);
  endtask

  // full rate on both sides for a long stretch
  task automatic test_back_to_back();
    src_gaps   = 1'b0;
    snk_stalls = 1'b0;
    set_config(FMT_S16, 1'b0);
    send_random(300);
    src_gaps   = 1'b1;
    snk_stalls = 1'b1;
  endtask

  // hold the output long enough for the row to fill and stall the input
  task automatic test_output_backpressure();
    set_config(FMT_U8, 1'b0);
    src_gaps     = 1'b0;
    hold_pending = 1'b1;
    send_random(120);
    src_gaps = 1'b1;
  endtask

  // ---------------------------------------------------------------- output side

  always @(posedge clk_i) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left    = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (snk_stalls) begin
      m_axis_tready <= ($urandom_range(99) >= 22);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_out
    mix_out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_mix_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_PRINT)
          $display("%0t: unexpected mixed word %h clipped %b", $time, m_axis_tdata,
                   m_axis_tuser);
      end else begin
        want = expected_mix_q.pop_front();
        if (m_axis_tdata !== want.mixed) begin
          err_count++;
          if (err_count <= MAX_PRINT)
            $display("%0t: mixed_sample expected %h actual %h", $time, want.mixed,
                     m_axis_tdata);
        end
        if (m_axis_tuser !== want.clip) begin
          err_count++;
          if (err_count <= MAX_PRINT)
            $display("%0t: clipped expected %b actual %b", $time, want.clip, m_axis_tuser);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_random_formats();
    test_muted();
    test_back_to_back();
    test_output_backpressure();
    drain();
    repeat (NSTR + 8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #200_000;
    $display("%0t: timeout, %0d words still outstanding", $time, expected_mix_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
